[hw/rtl/hcpg_pkg.sv]
package hcpg_pkg;

  // Curve resolution default and widths
  localparam int unsigned StepsDef = 1000;
  localparam int unsigned KW       = 10;   // step index width
  localparam int unsigned CoordW   = 16;   // coordinate width

  // Configuration register file
  localparam int unsigned NumCfg  = 8;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned CfgSelW = $clog2(NumCfg);

  localparam logic [CfgSelW-1:0] CfgStartX       = 3'd0;
  localparam logic [CfgSelW-1:0] CfgStartY       = 3'd1;
  localparam logic [CfgSelW-1:0] CfgStartHandleX = 3'd2;
  localparam logic [CfgSelW-1:0] CfgStartHandleY = 3'd3;
  localparam logic [CfgSelW-1:0] CfgEndHandleX   = 3'd4;
  localparam logic [CfgSelW-1:0] CfgEndHandleY   = 3'd5;
  localparam logic [CfgSelW-1:0] CfgEndX         = 3'd6;
  localparam logic [CfgSelW-1:0] CfgEndY         = 3'd7;

  // Datapath widths, sized for the largest step count (1023)
  localparam int unsigned CoefW = 20;  // polynomial coefficients
  localparam int unsigned AccW  = 54;  // scaled numerator, also divider remainder
  localparam int unsigned SpW   = 31;  // powers of the step count
  localparam int unsigned QW    = 15;  // unsaturated quotient magnitude bits

  localparam logic signed [CoordW-1:0] CoordMax = 16'sh7FFF;
  localparam logic signed [CoordW-1:0] CoordMin = 16'sh8000;

  // Queue between front and back
  localparam int unsigned QDepth = 2;

  typedef struct packed {
    logic [KW-1:0] k;
    logic          last;
  } q_entry_t;

  typedef struct packed {
    logic idle;
    logic done;
  } lane_stat_t;

endpackage

[hw/rtl/hcpg_in_if.sv]
interface hcpg_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

[hw/rtl/hcpg_out_if.sv]
interface hcpg_out_if import hcpg_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] point_x;
  logic signed [CoordW-1:0] point_y;
  logic                     last;

  modport source (output valid, output point_x, output point_y, output last, input ready);
  modport sink   (input valid, input point_x, input point_y, input last, output ready);
endinterface

[hw/rtl/hcpg_front.sv]
module hcpg_front import hcpg_pkg::*; #(
  parameter int unsigned Steps = StepsDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  hcpg_in_if.sink  in_ch,
  input  logic     q_full_i,
  output logic     q_push_o,
  output q_entry_t q_entry_o
);

  localparam logic [KW-1:0] LastK = KW'(Steps);

  logic [KW-1:0] step_index_q, step_index_d;
  logic [KW-1:0] k_raw, k_sel;
  logic          last;

  // Pick the step of this tick; restart forces the first point
  always_comb begin
    k_raw = in_ch.restart ? '0 : step_index_q;
    k_sel = (k_raw > LastK) ? LastK : k_raw;
  end

  assign last        = (k_sel == LastK);
  assign in_ch.ready = !q_full_i;
  assign q_push_o    = in_ch.valid && !q_full_i;
  assign q_entry_o   = '{k: k_sel, last: last};

  // Advance the step counter on every transfer, wrap after the end point
  always_comb begin
    step_index_d = step_index_q;
    if (q_push_o) begin
      step_index_d = last ? '0 : k_sel + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_index_q <= '0;
    end else begin
      step_index_q <= step_index_d;
    end
  end

endmodule

[hw/rtl/hcpg_queue.sv]
module hcpg_queue import hcpg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t entry_i,
  input  logic     pop_i,
  output logic     full_o,
  output logic     empty_o,
  output q_entry_t entry_o
);

  localparam int unsigned PtrW = $clog2(QDepth);

  q_entry_t          mem_q [QDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]     count_q, count_d;

  assign full_o  = (count_q == (PtrW+1)'(QDepth));
  assign empty_o = (count_q == '0);
  assign entry_o = mem_q[rd_ptr_q];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

[hw/rtl/hcpg_axis.sv]
module hcpg_axis import hcpg_pkg::*; #(
  parameter int unsigned Steps = StepsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic                     ack_i,
  input  logic [KW-1:0]            k_i,
  input  logic signed [CoordW-1:0] p0_i,
  input  logic signed [CoordW-1:0] p1_i,
  input  logic signed [CoordW-1:0] p2_i,
  input  logic signed [CoordW-1:0] p3_i,
  output lane_stat_t               stat_o,
  output logic signed [CoordW-1:0] result_o
);

  localparam logic [63:0] SPow1 = 64'(Steps);
  localparam logic [63:0] SPow2 = SPow1 * SPow1;
  localparam logic [63:0] SPow3 = SPow2 * SPow1;

  // Rounding: q = (2|num| + D) / 2D with D = Steps^3
  localparam logic [AccW-1:0] Den    = AccW'(SPow3);
  localparam logic [AccW-1:0] SatLim = AccW'(SPow3 << (QW + 1));

  // Divide by 2D as a multiply by ceil(2^(RemW+DivL) / 2D); exact for any
  // dividend below 2^RemW, which the saturation check guarantees
  localparam int unsigned     RemW    = QW + SpW;
  localparam logic [63:0]     DivSorW = SPow3 << 1;
  localparam int unsigned     DivL    = $clog2(DivSorW);
  localparam int unsigned     RcpW    = RemW + 1;
  localparam int unsigned     QShift  = RemW + DivL;
  localparam logic [127:0]    RcpNum  = 128'(1) << QShift;
  localparam logic [RcpW-1:0] Rcp     =
      RcpW'((RcpNum + 128'(DivSorW) - 128'(1)) / 128'(DivSorW));
  localparam int unsigned     XLoW    = 23;
  localparam int unsigned     MLoW    = 24;
  localparam int unsigned     MacW    = RemW + RcpW;

  localparam int unsigned CntW = 4;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StHorn = 3'd1;
  localparam logic [2:0] StPrep = 3'd2;
  localparam logic [2:0] StChk  = 3'd3;
  localparam logic [2:0] StMul  = 3'd4;
  localparam logic [2:0] StSign = 3'd5;
  localparam logic [2:0] StDone = 3'd6;

  logic [2:0]               state_q, state_d;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic [KW-1:0]            k_q, k_d;
  logic signed [AccW-1:0]   acc_q, acc_d;
  logic [AccW-1:0]          rem_q, rem_d;
  logic [MacW-1:0]          mac_q, mac_d;
  logic                     neg_q, neg_d;
  logic signed [CoordW-1:0] res_q, res_d;

  logic signed [CoefW-1:0]  e0, e1, e2, e3;
  logic signed [CoefW-1:0]  c3, c2, c1, c0;
  logic signed [CoefW-1:0]  coef_sel;
  logic [SpW-1:0]           spow_sel;
  logic signed [AccW+KW:0]  prod;
  logic signed [AccW-1:0]   term;
  logic signed [AccW-1:0]   horner_nxt;
  logic [AccW-1:0]          acc_mag;
  logic [XLoW-1:0]          x_sel;
  logic [MLoW-1:0]          m_sel;
  logic [XLoW+MLoW-1:0]     pp;
  logic [MacW-1:0]          pp_sh;
  logic [CoordW-1:0]        quo_ext;

  // Hermite basis folded into power-basis coefficients
  always_comb begin
    e0 = CoefW'(p0_i);
    e1 = CoefW'(p1_i);
    e2 = CoefW'(p2_i);
    e3 = CoefW'(p3_i);
    c3 = e0 + e1 + e2 - e3 - e3 - e3;
    c2 = (e3 <<< 2) - e0 - (e1 <<< 1) - e2;
    c1 = e1 - e0;
    c0 = e0;
  end

  // Horner step: acc * k + c_j * Steps^(3-j)
  always_comb begin
    case (cnt_q)
      4'd0: begin
        coef_sel = c2;
        spow_sel = SpW'(SPow1);
      end
      4'd1: begin
        coef_sel = c1;
        spow_sel = SpW'(SPow2);
      end
      default: begin
        coef_sel = c0;
        spow_sel = SpW'(SPow3);
      end
    endcase
    prod       = acc_q * $signed({1'b0, k_q});
    term       = AccW'(coef_sel * $signed({1'b0, spow_sel}));
    horner_nxt = $signed(prod[AccW-1:0]) + term;
  end

  // Reciprocal multiply, one partial product per cycle
  always_comb begin
    case (cnt_q)
      4'd0: begin
        x_sel = rem_q[XLoW-1:0];
        m_sel = Rcp[MLoW-1:0];
      end
      4'd1: begin
        x_sel = rem_q[XLoW-1:0];
        m_sel = MLoW'(Rcp[RcpW-1:MLoW]);
      end
      4'd2: begin
        x_sel = rem_q[RemW-1:XLoW];
        m_sel = Rcp[MLoW-1:0];
      end
      default: begin
        x_sel = rem_q[RemW-1:XLoW];
        m_sel = MLoW'(Rcp[RcpW-1:MLoW]);
      end
    endcase
    pp = x_sel * m_sel;
    case (cnt_q)
      4'd0:    pp_sh = MacW'(pp);
      4'd1:    pp_sh = MacW'(pp) << MLoW;
      4'd2:    pp_sh = MacW'(pp) << XLoW;
      default: pp_sh = MacW'(pp) << (XLoW + MLoW);
    endcase
  end

  assign acc_mag = acc_q[AccW-1] ? AccW'(-acc_q) : AccW'(acc_q);
  assign quo_ext = {1'b0, mac_q[QShift +: QW]};

  // Sequencer: Horner, setup, saturation check, reciprocal multiply, sign; saturation skips to done
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    k_d     = k_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    mac_d   = mac_q;
    neg_d   = neg_q;
    res_d   = res_q;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          k_d     = k_i;
          acc_d   = AccW'(c3);
          cnt_d   = '0;
          state_d = StHorn;
        end
      end
      StHorn: begin
        acc_d = horner_nxt;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 4'd2) begin
          state_d = StPrep;
        end
      end
      StPrep: begin
        neg_d   = acc_q[AccW-1];
        rem_d   = (acc_mag << 1) + Den;
        state_d = StChk;
      end
      StChk: begin
        if (rem_q >= SatLim) begin
          res_d   = neg_q ? CoordMin : CoordMax;
          state_d = StDone;
        end else begin
          cnt_d   = '0;
          mac_d   = '0;
          state_d = StMul;
        end
      end
      StMul: begin
        mac_d = mac_q + pp_sh;
        if (cnt_q == 4'd3) begin
          state_d = StSign;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      StSign: begin
        res_d   = neg_q ? $signed(-quo_ext) : $signed(quo_ext);
        state_d = StDone;
      end
      StDone: begin
        if (ack_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q   <= k_d;
    acc_q <= acc_d;
    rem_q <= rem_d;
    mac_q <= mac_d;
    neg_q <= neg_d;
    res_q <= res_d;
  end

  assign stat_o   = '{idle: (state_q == StIdle), done: (state_q == StDone)};
  assign result_o = res_q;

endmodule

[hw/rtl/hcpg_back.sv]
module hcpg_back import hcpg_pkg::*; #(
  parameter int unsigned Steps = StepsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     q_empty_i,
  input  q_entry_t                 q_entry_i,
  output logic                     q_pop_o,
  input  logic signed [CoordW-1:0] cfg_i [NumCfg],
  hcpg_out_if.source               out_ch
);

  logic                     busy_q, busy_d;
  logic                     last_q, last_d;
  logic                     out_valid_q, out_valid_d;
  logic signed [CoordW-1:0] out_x_q, out_x_d;
  logic signed [CoordW-1:0] out_y_q, out_y_d;
  logic                     out_last_q, out_last_d;
  logic                     fin;
  lane_stat_t               stat_x, stat_y;
  logic signed [CoordW-1:0] res_x, res_y;

  // Take the next step once the lanes are free
  assign q_pop_o = !busy_q && !q_empty_i;

  // Retire when both lanes are done and the output slot is free or draining
  assign fin = busy_q && stat_x.done && stat_y.done && (!out_valid_q || out_ch.ready);

  hcpg_axis #(.Steps(Steps)) u_axis_x (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (q_pop_o),
    .ack_i    (fin),
    .k_i      (q_entry_i.k),
    .p0_i     (cfg_i[CfgStartX]),
    .p1_i     (cfg_i[CfgStartHandleX]),
    .p2_i     (cfg_i[CfgEndHandleX]),
    .p3_i     (cfg_i[CfgEndX]),
    .stat_o   (stat_x),
    .result_o (res_x)
  );

  hcpg_axis #(.Steps(Steps)) u_axis_y (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (q_pop_o),
    .ack_i    (fin),
    .k_i      (q_entry_i.k),
    .p0_i     (cfg_i[CfgStartY]),
    .p1_i     (cfg_i[CfgStartHandleY]),
    .p2_i     (cfg_i[CfgEndHandleY]),
    .p3_i     (cfg_i[CfgEndY]),
    .stat_o   (stat_y),
    .result_o (res_y)
  );

  // Job tracking and output register
  always_comb begin
    busy_d      = busy_q;
    last_d      = last_q;
    out_valid_d = out_valid_q;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;
    out_last_d  = out_last_q;
    if (out_ch.ready) begin
      out_valid_d = 1'b0;
    end
    if (q_pop_o) begin
      busy_d = 1'b1;
      last_d = q_entry_i.last;
    end
    if (fin) begin
      busy_d      = 1'b0;
      out_valid_d = 1'b1;
      out_x_d     = res_x;
      out_y_d     = res_y;
      out_last_d  = last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q     <= last_d;
    out_x_q    <= out_x_d;
    out_y_q    <= out_y_d;
    out_last_q <= out_last_d;
  end

  assign out_ch.valid   = out_valid_q;
  assign out_ch.point_x = out_x_q;
  assign out_ch.point_y = out_y_q;
  assign out_ch.last    = out_last_q;

  // Lanes only run while a job is open
  a_idle_lanes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (stat_x.idle && stat_y.idle))
    else $error("lane active without an open job");

  // A pop starts both lanes
  a_pop_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> (busy_q && !stat_x.idle && !stat_y.idle))
    else $error("lanes did not start after pop");

  // Retiring fills the output slot and closes the job
  a_fin_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin |=> (out_valid_q && !busy_q))
    else $error("retired point not presented");

  // A retired point never overwrites a waiting one
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ch.ready) |-> !fin)
    else $error("output overwritten while stalled");

endmodule

[hw/rtl/hermite_curve_point_generator_top.sv]
// Channel | Dir | Payload              | Transfer
// in_ch   | in  | restart              | valid && ready
// out_ch  | out | point_x, point_y,    | valid && ready
//         |     | last                 |
// cfg     | in  | cfg_idx_i, cfg_wdata | cfg_we_i (no wait)
//
// Each point passes from queue pop to the output register through 3 Horner
// multiply-add steps, setup, a saturation check, a reciprocal multiply in four
// partial products for the divide by 2*Steps^3 (one partial product per cycle),
// sign fix and retire; a saturated point skips the multiply. Both axes run in
// parallel lanes. The next pop waits for retire to free the lanes, so the back
// works one point at a time; a stalled output holds retire back.
// The front takes ticks into a 2-entry queue while the back works, and the
// back starts the next point while a finished one waits at the output.
// Reset clears the step counter, queue pointers, lane states, output valid and
// control points; datapath registers are left as they are.
module hermite_curve_point_generator_top import hcpg_pkg::*; #(
  parameter int unsigned Steps = StepsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  hcpg_in_if.sink            in_ch,
  hcpg_out_if.source         out_ch,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CoordW-1:0]  cfg_wdata_i
);

  logic signed [CoordW-1:0] cfg_q [NumCfg];
  logic                     q_push, q_pop, q_full, q_empty;
  q_entry_t                 q_in, q_out;

  // Control point registers; writes past the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumCfg; i++) begin
        cfg_q[i] <= '0;
      end
    end else if (cfg_we_i && (cfg_idx_i < CfgIdxW'(NumCfg))) begin
      cfg_q[cfg_idx_i[CfgSelW-1:0]] <= $signed(cfg_wdata_i);
    end
  end

  hcpg_front #(.Steps(Steps)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_ch     (in_ch),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_entry_o (q_in)
  );

  hcpg_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .entry_o (q_out)
  );

  hcpg_back #(.Steps(Steps)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_entry_i (q_out),
    .q_pop_o   (q_pop),
    .cfg_i     (cfg_q),
    .out_ch    (out_ch)
  );

endmodule
